// File: hdl/pds_pkg.sv
// Package for the priority decay process scheduler.
// Holds the table entry and cell types, sequencer codes and the priority key function.
// No dependencies.
package pds_pkg;

	localparam int SLOTS = 16;
	localparam int LIVE_W = $clog2(SLOTS + 1);
	localparam int IN_W = 32;
	localparam int OUT_W = 48;

	localparam logic [3:0] FULL_QUANTUM_RST = 4'd6;
	localparam logic [7:0] LAST_PID_RST = 8'd100;

	localparam logic CFG_FULL_QUANTUM = 1'b0;
	localparam logic CFG_LAST_PID = 1'b1;

	typedef enum logic [1:0] {
		ST_READY = 2'd1,
		ST_RUN = 2'd2,
		ST_BLOCK = 2'd3
	} pstate_t;

	typedef struct packed {
		logic [7:0] pid;
		logic [4:0] cpu;
		logic [4:0] maxt;
		logic [3:0] blk;
		logic [3:0] q;
		logic signed [4:0] pri;
		pstate_t st;
	} entry_t;

	typedef struct packed {
		logic valid;
		entry_t ent;
	} slot_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_RUN,
		OP_REMOVE,
		OP_INSERT,
		OP_DISPATCH,
		OP_UNBLOCK
	} op_t;

	typedef struct packed {
		op_t op;
		entry_t ins;
		logic [3:0] full_quantum;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic fin;
		logic yld;
		logic pblk;
		logic unb;
		logic [7:0] pid;
		entry_t moved;
	} rpt_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RUN,
		S_REMOVE,
		S_INSY,
		S_DISP,
		S_UNB,
		S_ARR,
		S_REP
	} sched_state_t;

	// Negative priorities down to -15 map below zero, nearest zero first.
	function automatic logic signed [5:0] prio_key(input logic signed [4:0] p);
		logic signed [5:0] ext;
		ext = {p[4], p};
		return p[4] ? (6'sb110000 - ext) : ext;
	endfunction

endpackage

// File: hdl/priority_decay_process_scheduler.sv
// Top level of the priority decay process scheduler: sequencer and row of table cells.
// Depends on pds_pkg and pds_cell.
// A transfer takes the cell row through the run, dispatch, unblock and arrival phases, with
// a remove phase after run when the running process finishes, plus a reinsert when it yields;
// the next transfer is taken only after the result is registered and the sequencer is idle.
// Reset empties the table, sets the next id to 1 and the registers to their defaults.
module priority_decay_process_scheduler import pds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// arrive, arrive_max_time, arrive_block_time, unblock_mask, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// running_pid, finished_pid, preempted_pid, preempt_blocked, process_count,
	// upcoming_pid, arrival_dropped, idle_cpu, sim_done, zero fill
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data
);

	sched_state_t state_q, state_d;

	logic [3:0] full_quantum_q;
	logic [7:0] last_pid_q;
	logic [LIVE_W-1:0] live_q;
	logic [7:0] pid_q;
	logic pending_q, ready_q, nothing_q;
	logic yld_q;

	logic arrive_q;
	logic [4:0] amax_q;
	logic [3:0] ablk_q;
	logic [15:0] mask_q;

	logic [7:0] fin_pid_q, pre_pid_q;
	logic pblk_q, dropped_q, idle_q;
	entry_t moved_q;

	logic m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	cmd_t cmd;
	entry_t arr_ent;
	slot_t slots [SLOTS];
	logic [SLOTS:0] chain;
	logic [SLOTS-1:0] ub;
	rpt_t rpts [SLOTS];
	rpt_t rpt_all;
	logic room, out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign room = live_q < LIVE_W'(SLOTS);
	assign out_free = !m_valid_q || m_tready;
	assign chain[0] = 1'b0;

	always_comb begin
		arr_ent = '0;
		arr_ent.pid = pid_q;
		arr_ent.maxt = amax_q;
		arr_ent.blk = ablk_q;
		arr_ent.st = ST_READY;
	end

	always_comb begin
		rpt_all = '0;
		for (int i = 0; i < SLOTS; i++) begin
			rpt_all = rpt_all | rpts[i];
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		slot_t left_s, right_s;
		if (i == 0) begin : g_first
			assign left_s = '0;
		end else begin : g_mid
			assign left_s = slots[i-1];
		end
		if (i == SLOTS - 1) begin : g_last
			assign right_s = '0;
		end else begin : g_body
			assign right_s = slots[i+1];
		end
		if (i < 16) begin : g_mask
			assign ub[i] = mask_q[i];
		end else begin : g_nomask
			assign ub[i] = 1'b0;
		end
		pds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.unblock   (ub[i]),
			.left      (left_s),
			.right     (right_s),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.slot_o    (slots[i]),
			.rpt       (rpts[i])
		);
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_IDLE;
		cmd.ins = (state_q == S_INSY) ? moved_q : arr_ent;
		cmd.full_quantum = full_quantum_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				cmd.op = OP_RUN;
				state_d = (rpt_all.fin || rpt_all.yld) ? S_REMOVE : S_DISP;
			end
			S_REMOVE: begin
				cmd.op = OP_REMOVE;
				state_d = yld_q ? S_INSY : S_DISP;
			end
			S_INSY: begin
				cmd.op = OP_INSERT;
				state_d = S_DISP;
			end
			S_DISP: begin
				cmd.op = pending_q ? OP_DISPATCH : OP_IDLE;
				state_d = S_UNB;
			end
			S_UNB: begin
				cmd.op = OP_UNBLOCK;
				state_d = S_ARR;
			end
			S_ARR: begin
				cmd.op = (arrive_q && room) ? OP_INSERT : OP_IDLE;
				state_d = S_REP;
			end
			S_REP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_quantum_q <= FULL_QUANTUM_RST;
			last_pid_q <= LAST_PID_RST;
			live_q <= '0;
			pid_q <= 8'd1;
			pending_q <= 1'b1;
			ready_q <= 1'b0;
			nothing_q <= 1'b0;
			yld_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FULL_QUANTUM: full_quantum_q <= cfg_data[3:0];
					CFG_LAST_PID: last_pid_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == S_REP) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && ready_q && nothing_q) begin
						pending_q <= 1'b1;
					end
				end
				S_RUN: begin
					yld_q <= rpt_all.yld;
					if (rpt_all.fin || rpt_all.yld) begin
						pending_q <= 1'b1;
						ready_q <= 1'b0;
					end
				end
				S_REMOVE: begin
					live_q <= live_q - LIVE_W'(1);
				end
				S_INSY: begin
					live_q <= live_q + LIVE_W'(1);
				end
				S_DISP: begin
					if (pending_q) begin
						nothing_q <= !rpt_all.hit;
						pending_q <= 1'b0;
					end
				end
				S_UNB: begin
					if (rpt_all.unb) begin
						ready_q <= 1'b1;
					end
				end
				S_ARR: begin
					if (arrive_q && room) begin
						live_q <= live_q + LIVE_W'(1);
						ready_q <= 1'b1;
						if (pid_q != 8'd255) begin
							pid_q <= pid_q + 8'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				arrive_q <= s_tdata[0];
				amax_q <= s_tdata[5:1];
				ablk_q <= s_tdata[9:6];
				mask_q <= s_tdata[25:10];
				fin_pid_q <= 8'd0;
				pre_pid_q <= 8'd0;
				pblk_q <= 1'b0;
				dropped_q <= 1'b0;
				idle_q <= 1'b0;
			end
			S_RUN: begin
				if (rpt_all.fin) begin
					fin_pid_q <= rpt_all.pid;
				end
				if (rpt_all.yld) begin
					pre_pid_q <= rpt_all.pid;
					pblk_q <= rpt_all.pblk;
					moved_q <= rpt_all.moved;
				end
			end
			S_DISP: begin
				if (pending_q) begin
					idle_q <= !rpt_all.hit;
				end
			end
			S_ARR: begin
				dropped_q <= arrive_q && !room;
			end
			S_REP: begin
				if (out_free) begin
					m_data_q <= {7'd0, (pid_q > last_pid_q), idle_q, dropped_q, pid_q,
						5'(live_q), pblk_q, pre_pid_q, fin_pid_q, rpt_all.pid};
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/pds_cell.sv
// One table position of the scheduler's cell row.
// Depends on pds_pkg for the entry, command and report types.
module pds_cell import pds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  logic  unblock,
	input  slot_t left,
	input  slot_t right,
	input  logic  chain_in,
	output logic  chain_out,
	output slot_t slot_o,
	output rpt_t  rpt
);

	entry_t ent_q;
	logic valid_q;
	logic mark_q;

	entry_t ent_d;
	logic valid_d;
	logic mark_d;

	logic is_run, is_ready, is_block, gt;
	logic [3:0] q1;
	logic [4:0] cpu1;
	logic fin, yld, blocked;
	logic [3:0] absp;
	logic [5:0] sum;
	logic [3:0] mag;
	entry_t upd, moved;

	always_comb begin
		is_run = valid_q && (ent_q.st == ST_RUN);
		is_ready = valid_q && (ent_q.st == ST_READY);
		is_block = valid_q && (ent_q.st == ST_BLOCK);
		gt = !valid_q || (prio_key(ent_q.pri) > prio_key(cmd.ins.pri));

		q1 = (ent_q.q == 4'd15) ? 4'd15 : ent_q.q + 4'd1;
		cpu1 = (ent_q.cpu == 5'd31) ? 5'd31 : ent_q.cpu + 5'd1;
		fin = cpu1 >= ent_q.maxt;
		yld = q1 >= ent_q.blk;
		absp = ent_q.pri[4] ? 4'(-ent_q.pri) : ent_q.pri[3:0];
		sum = {2'b00, absp} + {2'b00, q1} + 6'd1;
		mag = sum[4:1];
		blocked = q1 < cmd.full_quantum;

		upd = ent_q;
		upd.q = q1;
		upd.cpu = cpu1;
		moved = upd;
		moved.q = 4'd0;
		moved.st = blocked ? ST_BLOCK : ST_READY;
		moved.pri = blocked ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

		ent_d = ent_q;
		valid_d = valid_q;
		mark_d = mark_q;
		rpt = '0;

		case (cmd.op)
			OP_RUN: begin
				chain_out = chain_in | is_run;
				if (is_run && !chain_in) begin
					rpt.hit = 1'b1;
					rpt.pid = ent_q.pid;
					if (fin) begin
						rpt.fin = 1'b1;
						mark_d = 1'b1;
					end else if (yld) begin
						rpt.yld = 1'b1;
						rpt.pblk = blocked;
						rpt.moved = moved;
						mark_d = 1'b1;
					end else begin
						ent_d = upd;
					end
				end
			end
			OP_REMOVE: begin
				chain_out = chain_in | mark_q;
				mark_d = 1'b0;
				if (chain_in || mark_q) begin
					ent_d = right.ent;
					valid_d = right.valid;
				end
			end
			OP_INSERT: begin
				chain_out = gt;
				if (chain_in) begin
					ent_d = left.ent;
					valid_d = left.valid;
				end else if (gt) begin
					ent_d = cmd.ins;
					valid_d = 1'b1;
				end
			end
			OP_DISPATCH: begin
				chain_out = chain_in | is_ready;
				if (is_ready && !chain_in) begin
					rpt.hit = 1'b1;
					ent_d.st = ST_RUN;
				end
			end
			OP_UNBLOCK: begin
				chain_out = chain_in | is_run;
				if (unblock && is_block) begin
					rpt.unb = 1'b1;
					ent_d.st = ST_READY;
				end
			end
			default: begin
				chain_out = chain_in | is_run;
				if (is_run && !chain_in) begin
					rpt.hit = 1'b1;
					rpt.pid = ent_q.pid;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			mark_q <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign slot_o = '{valid: valid_q, ent: ent_q};

endmodule
